/* src/tccw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, constants and helpers for the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // Item actions carried on the input tuser
    typedef enum logic [1:0] {
        ACT_CHAR     = 2'd0,
        ACT_DEC      = 2'd1,
        ACT_HEX_BYTE = 2'd2,
        ACT_HEX_WORD = 2'd3
    } action_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W    = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTRIBUTE  = 8'd1;

    // Reset values of the configuration registers
    localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;
    localparam logic [7:0] ATTRIBUTE_RESET  = 8'h03;

    // Character codes
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] MINUS_CHAR   = 8'h2d;
    localparam logic [3:0] DIGIT_ZONE   = 4'h3;

    // Decimal conversion geometry
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned DIGIT_W       = 4;
    localparam int unsigned DEC_DIGITS    = 10;
    localparam int unsigned BCD_W         = DIGIT_W * DEC_DIGITS;
    localparam int unsigned BITS_PER_STEP = 4;
    localparam int unsigned CONV_STEPS    = VALUE_W / BITS_PER_STEP;

    // Character queue: sign plus ten digits at most
    localparam int unsigned QUEUE_DEPTH = DEC_DIGITS + 1;
    localparam int unsigned QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned HEX_WORD_CHARS = VALUE_W / DIGIT_W;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic dec_load;
        logic emit;
    } tccw_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        action_t action;
        logic    newline;
        logic    skip_done;
        logic    queue_last;
        logic    out_free;
    } tccw_stat_t;

    // Uppercase hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = {DIGIT_ZONE, nib};
        end
        else begin
            ch = 8'h37 + {4'h0, nib};
        end
        return ch;
    endfunction

endpackage

/* src/tccw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer: accepts an item, steps the decimal conversion, trims leading
// zeros and paces the cell writes against the output register.
// ----------------------------------------------------------------------------
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  tccw_stat_t stat,
    output tccw_cmd_t  cmd
);

    localparam int unsigned CNT_W = $clog2(CONV_STEPS);
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ready_reg, ready_next;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (stat.action == ACT_DEC)
                    begin
                        state_next = ST_CONV;
                    end
                    else if (!stat.newline)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (stat.skip_done)
                begin
                    cmd.dec_load = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.skip_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.queue_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    // Hold state, step counter and ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

/* src/tccw_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_dpath
// Datapath: configuration, cursor, binary to BCD converter, character queue
// and the output beat register.
// ----------------------------------------------------------------------------
module tccw_dpath
    import tccw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_W-1:0]     s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,
    output logic                   m_tlast,
    input  tccw_cmd_t              cmd,
    output tccw_stat_t             stat
);

    logic [7:0]          line_width_reg, attribute_reg;
    logic [7:0]          cursor_line_reg, cursor_line_next;
    logic [7:0]          cursor_col_reg, cursor_col_next;
    logic                sign_reg, sign_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [QCOUNT_W-1:0] ndig_reg, ndig_next;
    logic [7:0]          q_reg [QUEUE_DEPTH];
    logic [7:0]          q_next [QUEUE_DEPTH];
    logic [QCOUNT_W-1:0] count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         out_addr_reg, out_addr_next;
    logic [15:0]         out_word_reg, out_word_next;
    logic                out_last_reg, out_last_next;
    logic [BCD_W-1:0]    bcd_step;
    logic [VALUE_W-1:0]  value_step;
    logic [15:0]         line_base;
    logic                out_free;

    // Status towards the controller
    assign out_free        = !out_valid_reg || m_tready;
    assign stat.action     = action_t'(s_tuser);
    assign stat.newline    = (action_t'(s_tuser) == ACT_CHAR) && (s_tdata[7:0] == NEWLINE_CHAR);
    assign stat.skip_done  = (bcd_reg[BCD_W-1 -: DIGIT_W] != '0) || (ndig_reg == QCOUNT_W'(1));
    assign stat.queue_last = (count_reg == QCOUNT_W'(1));
    assign stat.out_free   = out_free;

    // Shift-add-3 conversion, several value bits per step
    always_comb
    begin
        bcd_step   = bcd_reg;
        value_step = value_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < DEC_DIGITS; d++)
            begin
                if (bcd_step[DIGIT_W*d +: DIGIT_W] >= 4'd5)
                begin
                    bcd_step[DIGIT_W*d +: DIGIT_W] = bcd_step[DIGIT_W*d +: DIGIT_W] + 4'd3;
                end
            end
            bcd_step   = {bcd_step[BCD_W-2:0], value_step[VALUE_W-1]};
            value_step = {value_step[VALUE_W-2:0], 1'b0};
        end
    end

    // Cell offset of the start of the cursor line
    assign line_base = {8'h00, cursor_line_reg} * {8'h00, line_width_reg};

    // Next values of cursor, converter, queue and output beat
    always_comb
    begin
        cursor_line_next = cursor_line_reg;
        cursor_col_next  = cursor_col_reg;
        sign_next        = sign_reg;
        value_next       = value_reg;
        bcd_next         = bcd_reg;
        ndig_next        = ndig_reg;
        q_next           = q_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_addr_next    = out_addr_reg;
        out_word_next    = out_word_reg;
        out_last_next    = out_last_reg;

        if (cmd.load)
        begin
            sign_next  = s_tdata[VALUE_W-1];
            value_next = s_tdata[VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
            bcd_next   = '0;
            ndig_next  = QCOUNT_W'(DEC_DIGITS);
            case (action_t'(s_tuser))
                ACT_CHAR:
                begin
                    q_next[0]  = s_tdata[7:0];
                    count_next = QCOUNT_W'(1);
                    if (s_tdata[7:0] == NEWLINE_CHAR)
                    begin
                        cursor_line_next = cursor_line_reg + 1'b1;
                        cursor_col_next  = '0;
                    end
                end
                ACT_HEX_BYTE:
                begin
                    q_next[0]  = hex_char(s_tdata[7:4]);
                    q_next[1]  = hex_char(s_tdata[3:0]);
                    count_next = QCOUNT_W'(2);
                end
                ACT_HEX_WORD:
                begin
                    for (int i = 0; i < HEX_WORD_CHARS; i++)
                    begin
                        q_next[i] = hex_char(s_tdata[VALUE_W-1-DIGIT_W*i -: DIGIT_W]);
                    end
                    count_next = QCOUNT_W'(HEX_WORD_CHARS);
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        // Advance the converter
        if (cmd.conv_step)
        begin
            bcd_next   = bcd_step;
            value_next = value_step;
        end

        // Drop one leading zero digit
        if (cmd.skip_step)
        begin
            bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            ndig_next = ndig_reg - 1'b1;
        end

        // Fill the queue with sign and digits
        if (cmd.dec_load)
        begin
            if (sign_reg)
            begin
                q_next[0] = MINUS_CHAR;
                for (int k = 0; k < DEC_DIGITS; k++)
                begin
                    q_next[k+1] = {DIGIT_ZONE, bcd_reg[BCD_W-1-DIGIT_W*k -: DIGIT_W]};
                end
                count_next = ndig_reg + 1'b1;
            end
            else
            begin
                for (int k = 0; k < DEC_DIGITS; k++)
                begin
                    q_next[k] = {DIGIT_ZONE, bcd_reg[BCD_W-1-DIGIT_W*k -: DIGIT_W]};
                end
                count_next = ndig_reg;
            end
        end

        // Write one cell and advance the column
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = line_base + {8'h00, cursor_col_reg};
            out_word_next   = {attribute_reg, q_reg[0]};
            out_last_next   = (count_reg == QCOUNT_W'(1));
            cursor_col_next = cursor_col_reg + 1'b1;
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= LINE_WIDTH_RESET;
            attribute_reg   <= ATTRIBUTE_RESET;
            cursor_line_reg <= '0;
            cursor_col_reg  <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == CFG_LINE_WIDTH))
            begin
                line_width_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == CFG_ATTRIBUTE))
            begin
                attribute_reg <= cfg_data;
            end
            cursor_line_reg <= cursor_line_next;
            cursor_col_reg  <= cursor_col_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sign_reg     <= sign_next;
        value_reg    <= value_next;
        bcd_reg      <= bcd_next;
        ndig_reg     <= ndig_next;
        q_reg        <= q_next;
        out_addr_reg <= out_addr_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_word_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* src/text_console_cell_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Prints characters, signed decimals and hex numbers as cell writes into a
// character-cell buffer, tracking a line and column cursor.
// ----------------------------------------------------------------------------
// Flow: a character or hex digit goes from the accepted beat into the character queue,
//   then into the output register, then one cell per cycle while m_tready is high.
// Decimal: load, conversion steps, trim of leading zeros and queue fill, then cells.
// Items: s_tready stays low until the last cell of an item enters the output register;
//   a newline only moves the cursor, and the next beat follows the last cell.
// Reset: line width 80, attribute 3, cursor at line 0 column 0, output empty.
module text_console_cell_writer
    import tccw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input beat
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [31:0] value
    input  logic [1:0]             s_tuser,   // [1:0] action
    // Cell write beat
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [15:0] cell_address, [31:16] cell_word
    output logic                   m_tlast,
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    tccw_cmd_t  cmd;
    tccw_stat_t stat;

    // The user writes registers only while idle; the block does not enforce it, so always take the beat
    assign cfg_ready = 1'b1;

    tccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tccw_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* src/tccw_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_chk
// Port-level checks for the text console cell writer, bound to the top level.
// ----------------------------------------------------------------------------
module tccw_chk
    import tccw_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [31:0]            s_tdata,
    input logic [1:0]             s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [31:0]            m_tdata,
    input logic                   m_tlast
);

    logic in_beat, is_newline;

    assign in_beat    = s_tvalid && s_tready;
    assign is_newline = (s_tuser == ACT_CHAR) && (s_tdata[7:0] == NEWLINE_CHAR);

    // A stalled cell beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("cell beat changed while stalled");

    // An item that prints something blocks the input for its duration
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && !is_newline |=> !s_tready)
        else $error("input ready while an item is in progress");

    // A newline only moves the cursor and leaves the block idle
    a_newline: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && is_newline |=> s_tready)
        else $error("newline did not return to idle");

    // While idle, any pending cell beat is the final one of its item
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tlast)
        else $error("idle with a non-final cell pending");

endmodule

bind text_console_cell_writer tccw_chk u_tccw_chk (.*);

/* tb/tb_text_console_cell_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer
// Self-checking bench for the text console cell writer. Items of every
// action go in on the input stream. A cursor-tracking scoreboard works out
// the cell beats each item must produce and checks them in order. Both
// stream sides idle at random, the receiver holds off once for a long
// stretch, and both registers are swept through several settings.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer
    import tccw_pkg::*;
();

    localparam int DRAIN_CYCLES = 40;    // longest decimal item plus margin
    localparam int HOLD_CYCLES  = 300;   // receiver hold-off for back-pressure

    // One expected cell beat
    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] word;
        logic        last;
    } cell_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the cursor and queues the cell beats per item
    // ------------------------------------------------------------------------
    class cell_scoreboard;
        logic [7:0] line_width;
        logic [7:0] attribute;
        logic [7:0] cur_line;
        logic [7:0] cur_col;
        cell_beat_t expected_cells[$];
        int         mismatches;
        int         cells_checked;

        function new();
            line_width    = LINE_WIDTH_RESET;
            attribute     = ATTRIBUTE_RESET;
            cur_line      = 8'd0;
            cur_col       = 8'd0;
            mismatches    = 0;
            cells_checked = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_LINE_WIDTH)
            begin
                line_width = data;
            end
            else if (idx == CFG_ATTRIBUTE)
            begin
                attribute = data;
            end
        endfunction

        // Place one character at the cursor, or move to the next line
        function void put_char(logic [7:0] ch);
            cell_beat_t beat;
            if (ch == NEWLINE_CHAR)
            begin
                cur_line = cur_line + 8'd1;
                cur_col  = 8'd0;
            end
            else
            begin
                beat.addr = ({8'd0, cur_line} * {8'd0, line_width}) + {8'd0, cur_col};
                beat.word = {attribute, ch};
                beat.last = 1'b0;
                expected_cells.push_back(beat);
                cur_col = cur_col + 8'd1;
            end
        endfunction

        function logic [7:0] hex_ascii(logic [3:0] nib);
            if (nib < 4'd10)
            begin
                return 8'h30 + {4'd0, nib};
            end
            return 8'h41 + {4'd0, nib} - 8'd10;
        endfunction

        // Work out the cell beats of one accepted item
        function void note_item(action_t act, logic [31:0] val);
            int          start_size;
            logic [31:0] mag;
            logic [7:0]  digits[10];
            int          n;
            cell_beat_t  tail;
            start_size = expected_cells.size();
            case (act)
                ACT_CHAR:
                begin
                    put_char(val[7:0]);
                end
                ACT_DEC:
                begin
                    mag = val;
                    if (val[31])
                    begin
                        put_char(MINUS_CHAR);
                        mag = 32'd0 - val;
                    end
                    n = 0;
                    do
                    begin
                        digits[n] = 8'h30 + 8'(mag % 32'd10);
                        mag = mag / 32'd10;
                        n++;
                    end
                    while (mag != 32'd0 && n < 10);
                    for (int i = n - 1; i >= 0; i--)
                    begin
                        put_char(digits[i]);
                    end
                end
                ACT_HEX_BYTE:
                begin
                    put_char(hex_ascii(val[7:4]));
                    put_char(hex_ascii(val[3:0]));
                end
                default:
                begin
                    for (int k = 7; k >= 0; k--)
                    begin
                        put_char(hex_ascii(val[4*k +: 4]));
                    end
                end
            endcase
            // Mark the final cell of the item
            if (expected_cells.size() > start_size)
            begin
                tail = expected_cells.pop_back();
                tail.last = 1'b1;
                expected_cells.push_back(tail);
            end
        endfunction

        function void report_mismatch(string what, logic [15:0] exp_v, logic [15:0] act_v);
            if (mismatches < 10)
            begin
                $display("%0t: cell %0d %s mismatch: expected %h, got %h",
                         $time, cells_checked, what, exp_v, act_v);
            end
            mismatches++;
        endfunction

        // Compare one cell beat with the oldest expectation
        function void check_cell(logic [15:0] addr, logic [15:0] word, logic last);
            cell_beat_t exp_beat;
            if (expected_cells.size() == 0)
            begin
                report_mismatch("unexpected beat address", 16'hxxxx, addr);
                return;
            end
            exp_beat = expected_cells.pop_front();
            if (addr !== exp_beat.addr)
            begin
                report_mismatch("address", exp_beat.addr, addr);
            end
            if (word !== exp_beat.word)
            begin
                report_mismatch("word", exp_beat.word, word);
            end
            if (last !== exp_beat.last)
            begin
                report_mismatch("last", {15'd0, exp_beat.last}, {15'd0, last});
            end
            cells_checked++;
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [31:0]            s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [31:0]            m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    cell_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    logic           hold_req;
    int             items_sent;
    int             reg_writes;

    text_console_cell_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #2ms;
        $display("Timeout with %0d cells still awaited", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check every accepted cell beat
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_cell(m_tdata[15:0], m_tdata[31:16], m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Offer one item, with a random gap first, and hold until taken
    task automatic send_item(input action_t act, input logic [31:0] val);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        do @(posedge clk); while (!s_tready);
        sb.note_item(act, val);
        items_sent++;
    endtask

    task automatic park_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Write one register once the block has gone quiet
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Random item, weighted towards interesting character and decimal values
    task automatic send_random_item();
        action_t     act;
        logic [31:0] val;
        int          pick;
        act  = action_t'($urandom_range(3));
        val  = $urandom;
        pick = $urandom_range(99);
        case (act)
            ACT_CHAR:
            begin
                if (pick < 12)
                begin
                    val[7:0] = NEWLINE_CHAR;
                end
            end
            ACT_DEC:
            begin
                if (pick < 20)
                begin
                    case ($urandom_range(5))
                        0: val = 32'h0000_0000;
                        1: val = 32'h8000_0000;
                        2: val = 32'hffff_ffff;
                        3: val = 32'h7fff_ffff;
                        4: val = 32'd9;
                        default: val = 32'd10;
                    endcase
                end
                else if (pick < 50)
                begin
                    val = $urandom_range(999);
                    if ($urandom_range(1))
                    begin
                        val = 32'd0 - val;
                    end
                end
            end
            default:
            begin
            end
        endcase
        send_item(act, val);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        sb            = new();
        send_idle_pct = 21;
        recv_idle_pct = 83;
        hold_req      = 1'b0;
        items_sent    = 0;
        reg_writes    = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 32'd0;
        s_tuser       = ACT_CHAR;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_LINE_WIDTH;
        cfg_data      = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at reset settings
        send_item(ACT_CHAR, 32'hffff_ff41);
        send_item(ACT_CHAR, 32'h0000_0000);
        send_item(ACT_CHAR, 32'h0000_00ff);
        send_item(ACT_CHAR, 32'h0000_000a);
        send_item(ACT_CHAR, 32'habcd_ef0a);
        send_item(ACT_CHAR, 32'h1234_5680);
        send_item(ACT_DEC, 32'h0000_0000);
        send_item(ACT_DEC, 32'h8000_0000);
        send_item(ACT_DEC, 32'hffff_ffff);
        send_item(ACT_DEC, 32'h7fff_ffff);
        send_item(ACT_DEC, 32'd1234567890);
        send_item(ACT_DEC, 32'd5);
        send_item(ACT_DEC, 32'hffff_fff6);
        send_item(ACT_HEX_BYTE, 32'hffff_ffaf);
        send_item(ACT_HEX_BYTE, 32'h0000_0000);
        send_item(ACT_HEX_BYTE, 32'h5a5a_5a09);
        send_item(ACT_HEX_WORD, 32'hdead_beef);
        send_item(ACT_HEX_WORD, 32'h0000_0000);
        send_item(ACT_HEX_WORD, 32'hffff_ffff);
        send_item(ACT_HEX_WORD, 32'h0123_4567);
        park_sender();

        // Widest lines, blank attribute; run the column past its wrap
        write_reg(CFG_LINE_WIDTH, 8'd255);
        write_reg(CFG_ATTRIBUTE, 8'd0);
        repeat (36) send_item(ACT_HEX_WORD, $urandom);
        repeat (60) send_random_item();
        park_sender();

        // Swap the idling sides; one-cell lines, full attribute; wrap the line
        send_idle_pct = 83;
        recv_idle_pct = 21;
        write_reg(CFG_LINE_WIDTH, 8'd1);
        write_reg(CFG_ATTRIBUTE, 8'd255);
        repeat (256) send_item(ACT_CHAR, {24'($urandom_range(32'hff_ffff)), NEWLINE_CHAR});
        repeat (60) send_random_item();
        park_sender();

        // No idling; zero width; stall the receiver so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_LINE_WIDTH, 8'd0);
        write_reg(CFG_ATTRIBUTE, 8'($urandom_range(255)));
        hold_req <= 1'b1;
        repeat (25) send_random_item();
        park_sender();

        // No idling; random settings
        write_reg(CFG_LINE_WIDTH, 8'($urandom_range(255, 1)));
        write_reg(CFG_ATTRIBUTE, 8'($urandom_range(255)));
        repeat (25) send_random_item();
        park_sender();

        // Drain and report
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items of all four actions, checked %0d cell beats", items_sent,
                 sb.cells_checked);
        $display("Covered %0d register writes, cursor wrap, both idling mixes and a hold-off",
                 reg_writes);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("%0d mismatches seen", sb.mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
